### src/ccexp_pkg.sv
`default_nettype none

package ccexp_pkg;

    // Configuration register file
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     CFG_RESET_DIM    = CFG_W'(4096);

    // Port widths of the sample and the result fields
    localparam int IN_W   = 16;
    localparam int INT_W  = 16;
    localparam int FRAC_W = 8;
    localparam int OUT_W  = INT_W + FRAC_W;

    // Window slots
    localparam int NUM_WIN = 5;
    localparam int WIN_C   = 0;
    localparam int WIN_TL  = 1;
    localparam int WIN_BL  = 2;
    localparam int WIN_TR  = 3;
    localparam int WIN_BR  = 4;

    // Division by six as multiply by ceil(2^18/6), exact below 2^17
    localparam int RECIP6_W   = 16;
    localparam logic [RECIP6_W-1:0] RECIP6 = RECIP6_W'(43691);
    localparam int DIV6_SHIFT = 18;

    // Cycles the geometry pipeline needs after a register write
    localparam logic [1:0] GEO_LAT = 2'd3;

    // Front-to-back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Classification of one sample
    typedef struct packed {
        logic [NUM_WIN-1:0] hit;
        logic               last;
    } ccexp_tag_t;

    localparam int TAG_W = $bits(ccexp_tag_t);

endpackage

`default_nettype wire

### src/ccexp_front.sv
`default_nettype none

module ccexp_front
    import ccexp_pkg::*;
#(
    parameter int MAX_DIM     = 8192,
    parameter int SAMPLE_BITS = 16,
    parameter int DIM_W       = $clog2(MAX_DIM + 1),
    parameter int POS_W       = $clog2(MAX_DIM)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [IN_W-1:0]        s_sample_value,
    input  wire logic                   q_full,
    output logic                        q_push,
    output logic [SAMPLE_BITS-1:0]      q_sample,
    output ccexp_tag_t                  q_tag,
    output logic [2*DIM_W-1:0]          box_area
);

    localparam int PROD_W = DIM_W + RECIP6_W;

    logic [CFG_W-1:0]   cfg_w_reg, cfg_h_reg;
    logic [1:0]         geo_cnt_reg;
    logic [DIM_W-1:0]   w_eff_reg, h_eff_reg;
    logic [DIM_W-1:0]   bw_reg, bh_reg;
    logic [DIM_W-1:0]   cx_reg, cy_reg, rx_reg, by_reg, wl_reg, hl_reg;
    logic [2*DIM_W-1:0] n_reg;
    logic [POS_W-1:0]   col_reg, row_reg;

    logic [PROD_W-1:0]  w_prod, h_prod;
    logic [DIM_W-1:0]   bw_q, bh_q;
    logic [DIM_W-1:0]   x_ext, y_ext;
    logic               left, right, top, bottom, in_cx, in_cy;
    logic               end_row, end_frame;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] raw);
        if (raw == '0) begin
            return DIM_W'(1);
        end
        if (32'(raw) > 32'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(raw);
    endfunction

    function automatic logic in_span(input logic [DIM_W-1:0] p,
                                     input logic [DIM_W-1:0] lo,
                                     input logic [DIM_W-1:0] len);
        return (p >= lo) && ((p - lo) < len);
    endfunction

    // Take register writes; restart the geometry settle count
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg   <= CFG_RESET_DIM;
            cfg_h_reg   <= CFG_RESET_DIM;
            geo_cnt_reg <= GEO_LAT;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  cfg_w_reg <= cfg_data;
                    REG_FRAME_HEIGHT: cfg_h_reg <= cfg_data;
                    default: ;
                endcase
                geo_cnt_reg <= GEO_LAT;
            end else if (geo_cnt_reg != 2'd0) begin
                geo_cnt_reg <= geo_cnt_reg - 2'd1;
            end
        end
    end

    // Derive the box geometry over three register stages
    assign w_prod = PROD_W'(w_eff_reg) * PROD_W'(RECIP6);
    assign h_prod = PROD_W'(h_eff_reg) * PROD_W'(RECIP6);
    assign bw_q   = DIM_W'(w_prod >> DIV6_SHIFT);
    assign bh_q   = DIM_W'(h_prod >> DIV6_SHIFT);

    always_ff @(posedge aclk) begin
        w_eff_reg <= eff_dim(cfg_w_reg);
        h_eff_reg <= eff_dim(cfg_h_reg);
        bw_reg    <= (bw_q == '0) ? DIM_W'(1) : bw_q;
        bh_reg    <= (bh_q == '0) ? DIM_W'(1) : bh_q;
        rx_reg    <= w_eff_reg - bw_reg;
        by_reg    <= h_eff_reg - bh_reg;
        cx_reg    <= (w_eff_reg - bw_reg) >> 1;
        cy_reg    <= (h_eff_reg - bh_reg) >> 1;
        wl_reg    <= w_eff_reg - DIM_W'(1);
        hl_reg    <= h_eff_reg - DIM_W'(1);
        n_reg     <= (2*DIM_W)'(bw_reg) * (2*DIM_W)'(bh_reg);
    end

    assign box_area = n_reg;

    // Classify the current position against the five boxes
    assign x_ext  = DIM_W'(col_reg);
    assign y_ext  = DIM_W'(row_reg);
    assign left   = x_ext < bw_reg;
    assign top    = y_ext < bh_reg;
    assign right  = in_span(x_ext, rx_reg, bw_reg);
    assign bottom = in_span(y_ext, by_reg, bh_reg);
    assign in_cx  = in_span(x_ext, cx_reg, bw_reg);
    assign in_cy  = in_span(y_ext, cy_reg, bh_reg);

    assign end_row   = x_ext >= wl_reg;
    assign end_frame = end_row && (y_ext >= hl_reg);

    assign s_ready  = (geo_cnt_reg == 2'd0) && !cfg_valid && !q_full;
    assign q_push   = s_valid && s_ready;
    assign q_sample = SAMPLE_BITS'(s_sample_value);

    always_comb begin
        q_tag              = '0;
        q_tag.hit[WIN_C]   = in_cx && in_cy;
        q_tag.hit[WIN_TL]  = left && top;
        q_tag.hit[WIN_BL]  = left && bottom;
        q_tag.hit[WIN_TR]  = right && top;
        q_tag.hit[WIN_BR]  = right && bottom;
        q_tag.last         = end_frame;
    end

    // Advance the raster position on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (q_push) begin
            if (end_frame) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (end_row) begin
                col_reg <= '0;
                row_reg <= row_reg + POS_W'(1);
            end else begin
                col_reg <= col_reg + POS_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### src/ccexp_queue.sv
`default_nettype none

module ccexp_queue
    import ccexp_pkg::*;
#(
    parameter int WIDTH = 22
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  rvalid,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]    count_reg;

    assign full   = count_reg == (Q_AW+1)'(Q_DEPTH);
    assign rvalid = count_reg != '0;
    assign rdata  = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (Q_AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (Q_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

### src/ccexp_accum.sv
`default_nettype none

module ccexp_accum
    import ccexp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 45
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_valid,
    input  wire logic [SAMPLE_BITS-1:0] q_sample,
    input  wire ccexp_tag_t             q_tag,
    output logic                        q_pop,
    input  wire logic                   div_idle,
    output logic                        div_start,
    output logic [SUM_W-1:0]            win_total [NUM_WIN]
);

    logic [SUM_W-1:0] sum_reg  [NUM_WIN];
    logic [SUM_W-1:0] sum_next [NUM_WIN];

    // Hold a frame end until the divider is free
    assign q_pop     = q_valid && (!q_tag.last || div_idle);
    assign div_start = q_pop && q_tag.last;

    always_comb begin
        for (int i = 0; i < NUM_WIN; i++) begin
            sum_next[i]  = sum_reg[i] + (q_tag.hit[i] ? SUM_W'(q_sample) : '0);
            win_total[i] = sum_next[i];
        end
    end

    // Accumulate window sums; clear at frame end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_WIN; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (q_pop) begin
            for (int i = 0; i < NUM_WIN; i++) begin
                sum_reg[i] <= q_tag.last ? '0 : sum_next[i];
            end
        end
    end

endmodule

`default_nettype wire

### src/ccexp_div.sv
`default_nettype none

module ccexp_div
    import ccexp_pkg::*;
#(
    parameter int SUM_W = 45,
    parameter int DEN_W = 29
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [SUM_W-1:0]   win_total [NUM_WIN],
    input  wire logic [DEN_W-2:0]   box_area,
    output logic                    idle,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [OUT_W-1:0]        m_centre_mean,
    output logic [OUT_W-1:0]        m_left_mean,
    output logic [OUT_W-1:0]        m_right_mean
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_TEST  = 3'd2;
    localparam logic [2:0] ST_ITER  = 3'd3;
    localparam logic [2:0] ST_STORE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [1:0] OP_CENTRE = 2'd0;
    localparam logic [1:0] OP_LEFT   = 2'd1;
    localparam logic [1:0] OP_RIGHT  = 2'd2;

    localparam int CNT_W = $clog2(OUT_W);
    localparam int CMP_W = SUM_W + DEN_W + INT_W + 1;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] win_reg  [NUM_WIN];
    logic [SUM_W-1:0] win_next [NUM_WIN];
    logic [SUM_W:0]   num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [OUT_W-1:0] dvd_reg, dvd_next;
    logic [OUT_W-1:0] quo_reg, quo_next;
    logic [OUT_W-1:0] centre_reg, centre_next;
    logic [OUT_W-1:0] left_reg, left_next;
    logic [OUT_W-1:0] right_reg, right_next;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_centre_reg, m_centre_next;
    logic [OUT_W-1:0] m_left_reg, m_left_next;
    logic [OUT_W-1:0] m_right_reg, m_right_next;

    logic [DEN_W:0]   trial;
    logic             trial_ge;
    logic             sat;
    logic             out_free;

    assign idle          = state_reg == ST_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_centre_mean = m_centre_reg;
    assign m_left_mean   = m_left_reg;
    assign m_right_mean  = m_right_reg;

    assign trial    = {rem_reg, dvd_reg[OUT_W-1]};
    assign trial_ge = trial >= {1'b0, den_reg};
    assign sat      = CMP_W'(num_reg) >= (CMP_W'(den_reg) << INT_W);
    assign out_free = !m_valid_reg || m_ready;

    // Restoring divider: one quotient bit per cycle, three quotients per frame
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        quo_next      = quo_reg;
        centre_next   = centre_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_centre_next = m_centre_reg;
        m_left_next   = m_left_reg;
        m_right_next  = m_right_reg;
        for (int i = 0; i < NUM_WIN; i++) begin
            win_next[i] = win_reg[i];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    for (int i = 0; i < NUM_WIN; i++) begin
                        win_next[i] = win_total[i];
                    end
                    op_next    = OP_CENTRE;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // Form numerator and divisor of the current mean
                unique case (op_reg)
                    OP_CENTRE: begin
                        num_next = (SUM_W+1)'(win_reg[WIN_C]);
                        den_next = DEN_W'(box_area);
                    end
                    OP_LEFT: begin
                        num_next = (SUM_W+1)'(win_reg[WIN_TL])
                                 + (SUM_W+1)'(win_reg[WIN_BL]);
                        den_next = {box_area, 1'b0};
                    end
                    default: begin
                        num_next = (SUM_W+1)'(win_reg[WIN_TR])
                                 + (SUM_W+1)'(win_reg[WIN_BR]);
                        den_next = {box_area, 1'b0};
                    end
                endcase
                state_next = ST_TEST;
            end
            ST_TEST: begin
                // Saturate when the quotient cannot fit the result field
                if (sat) begin
                    quo_next   = '1;
                    state_next = ST_STORE;
                end else begin
                    rem_next   = DEN_W'(num_reg >> FRAC_W'(0) >> INT_W);
                    dvd_next   = {num_reg[INT_W-1:0], {FRAC_W{1'b0}}};
                    quo_next   = '0;
                    cnt_next   = CNT_W'(OUT_W - 1);
                    state_next = ST_ITER;
                end
            end
            ST_ITER: begin
                rem_next = trial_ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
                quo_next = {quo_reg[OUT_W-2:0], trial_ge};
                dvd_next = dvd_reg << 1;
                if (cnt_reg == '0) begin
                    state_next = ST_STORE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_STORE: begin
                unique case (op_reg)
                    OP_CENTRE: begin
                        centre_next = quo_reg;
                        op_next     = OP_LEFT;
                        state_next  = ST_LOAD;
                    end
                    OP_LEFT: begin
                        left_next  = quo_reg;
                        op_next    = OP_RIGHT;
                        state_next = ST_LOAD;
                    end
                    default: begin
                        right_next = quo_reg;
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_OUT: begin
                // Hand the result to the output register once it drains
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_centre_next = centre_reg;
                    m_left_next   = left_reg;
                    m_right_next  = right_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_CENTRE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        centre_reg   <= centre_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        m_centre_reg <= m_centre_next;
        m_left_reg   <= m_left_next;
        m_right_reg  <= m_right_next;
        for (int i = 0; i < NUM_WIN; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

endmodule

`default_nettype wire

### src/corner_centre_exposure_profile_core.sv
`default_nettype none

// Corner and centre exposure profile. Raw mosaic samples of a frame enter in
// raster order, one per cycle while s_ready is high; the frame size comes
// from registers 0 (width) and 1 (height). Five boxes of max(1, W/6) by
// max(1, H/6) pixels, at the centre and the four corners, are summed as the
// samples pass. At the frame's last pixel one result carries the centre mean
// and the left and right means (each the average of the two corner means on
// that side), unsigned 16.8, truncated and saturated at all ones. Samples are
// classified at the input and summed as they leave the queue. The three means
// come from one shared restoring divider, one quotient bit per cycle. Samples
// of the next frame keep flowing while the divider works; a second frame end
// waits until the divider is idle. After reset and after each register write
// the input holds off while the box geometry settles.
module corner_centre_exposure_profile_core
    import ccexp_pkg::*;
#(
    parameter int MAX_DIM     = 8192,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [IN_W-1:0]      s_sample_value,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [OUT_W-1:0]          m_centre_mean,
    output logic [OUT_W-1:0]          m_left_mean,
    output logic [OUT_W-1:0]          m_right_mean
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int SUM_W = SAMPLE_BITS + 2*DIM_W + 1;
    localparam int DEN_W = 2*DIM_W + 1;
    localparam int QW    = TAG_W + SAMPLE_BITS;

    logic                   q_push, q_full, q_pop, q_valid;
    logic [SAMPLE_BITS-1:0] push_sample, pop_sample;
    ccexp_tag_t             push_tag, pop_tag;
    logic [QW-1:0]          q_rdata;
    logic [2*DIM_W-1:0]     box_area;
    logic                   div_idle, div_start;
    logic [SUM_W-1:0]       win_total [NUM_WIN];

    ccexp_front #(
        .MAX_DIM     (MAX_DIM),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_sample       (push_sample),
        .q_tag          (push_tag),
        .box_area       (box_area)
    );

    ccexp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   ({push_tag, push_sample}),
        .full    (q_full),
        .pop     (q_pop),
        .rvalid  (q_valid),
        .rdata   (q_rdata)
    );

    assign pop_tag    = q_rdata[QW-1 -: TAG_W];
    assign pop_sample = q_rdata[SAMPLE_BITS-1:0];

    ccexp_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_sample  (pop_sample),
        .q_tag     (pop_tag),
        .q_pop     (q_pop),
        .div_idle  (div_idle),
        .div_start (div_start),
        .win_total (win_total)
    );

    ccexp_div #(
        .SUM_W (SUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (div_start),
        .win_total     (win_total),
        .box_area      (box_area),
        .idle          (div_idle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_centre_mean (m_centre_mean),
        .m_left_mean   (m_left_mean),
        .m_right_mean  (m_right_mean)
    );

endmodule

`default_nettype wire
